FILE: hw/rtl/far_pkg.sv
// Package for the fraction add and reduce block.
// Holds widths and the word types shared by the front end, back end and top level.
package far_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned NumBits = 33;
  localparam int unsigned DenBits = 31;

  typedef struct packed {
    logic signed [OperandWidth-1:0] a_num;
    logic signed [OperandWidth-1:0] a_den;
    logic signed [OperandWidth-1:0] b_num;
    logic signed [OperandWidth-1:0] b_den;
  } in_word_t;

  typedef struct packed {
    logic signed [NumBits-1:0] sum_num;
    logic [DenBits-1:0] sum_den;
    logic zero_den_error;
  } out_word_t;
endpackage

FILE: hw/rtl/far_front.sv
// Front end: accepts input words, forms the exact cross products and sum.
// Depends on far_pkg. Produces sign and magnitude of numerator and denominator.
module far_front #(
  parameter int unsigned OPERAND_WIDTH = far_pkg::OperandWidth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [OPERAND_WIDTH-1:0] a_num,
  input  logic signed [OPERAND_WIDTH-1:0] a_den,
  input  logic signed [OPERAND_WIDTH-1:0] b_num,
  input  logic signed [OPERAND_WIDTH-1:0] b_den,
  output logic q_valid,
  input  logic q_ready,
  output logic [2*OPERAND_WIDTH:0] q_nmag,
  output logic [2*OPERAND_WIDTH:0] q_dmag,
  output logic q_neg,
  output logic q_err
);
  localparam int unsigned W = OPERAND_WIDTH;
  localparam int unsigned PW = 2 * W;

  logic st1_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic sn1_r, sn2_r, sd_r, err_r;
  logic [PW-1:0] p1_r, p2_r, pd_r;
  logic st2_r;
  logic adv2;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  assign adv2 = st2_r && (!q_valid || q_ready);
  assign in_ready = !st1_r && !st2_r && !q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_r <= 1'b0;
      st2_r <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        st1_r <= 1'b1;
        an_r <= mag_of(a_num);
        ad_r <= mag_of(a_den);
        bn_r <= mag_of(b_num);
        bd_r <= mag_of(b_den);
        sn1_r <= a_num[W-1] ^ b_den[W-1];
        sn2_r <= b_num[W-1] ^ a_den[W-1];
        sd_r <= a_den[W-1] ^ b_den[W-1];
        err_r <= (a_den == '0) || (b_den == '0);
      end else if (st1_r) begin
        st1_r <= 1'b0;
        st2_r <= 1'b1;
        p1_r <= PW'(an_r) * PW'(bd_r);
        p2_r <= PW'(bn_r) * PW'(ad_r);
        pd_r <= PW'(ad_r) * PW'(bd_r);
      end
      if (adv2) begin
        st2_r <= 1'b0;
        q_valid <= 1'b1;
        q_err <= err_r;
        q_dmag <= {1'b0, pd_r};
        if (sn1_r == sn2_r) begin
          q_nmag <= {1'b0, p1_r} + {1'b0, p2_r};
          q_neg <= sn1_r ^ sd_r;
        end else if (p1_r >= p2_r) begin
          q_nmag <= {1'b0, p1_r - p2_r};
          q_neg <= sn1_r ^ sd_r;
        end else begin
          q_nmag <= {1'b0, p2_r - p1_r};
          q_neg <= sn2_r ^ sd_r;
        end
      end else if (q_valid && q_ready) begin
        q_valid <= 1'b0;
      end
    end
  end
endmodule

FILE: hw/rtl/far_back.sv
// Back end: binary gcd, then two restoring divisions by the gcd.
// Depends on far_pkg for the result word type.
module far_back #(
  parameter int unsigned OPERAND_WIDTH = far_pkg::OperandWidth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_ready,
  input  logic [2*OPERAND_WIDTH:0] q_nmag,
  input  logic [2*OPERAND_WIDTH:0] q_dmag,
  input  logic q_neg,
  input  logic q_err,
  output logic out_valid,
  input  logic out_ready,
  output far_pkg::out_word_t out_word
);
  import far_pkg::*;
  localparam int unsigned MW = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned CW = $clog2(MW + 1);

  typedef enum logic [2:0] {S_IDLE, S_GCD, S_SHIFT, S_DIVN, S_DIVD, S_OUT} state_t;
  state_t state_r;
  logic [MW-1:0] x_r, y_r, g_r, n_r, d_r, q_r, rem_r;
  logic [CW-1:0] k_r, cnt_r;
  logic neg_r, err_r;
  logic [MW:0] trial;
  logic [MW-1:0] src;

  assign q_ready = (state_r == S_IDLE);
  assign src = (state_r == S_DIVN) ? n_r : d_r;
  assign trial = {rem_r, src[cnt_r[CW-1:0] - 1'b1]} - {1'b0, g_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            n_r <= q_nmag;
            d_r <= q_dmag;
            neg_r <= q_neg;
            err_r <= q_err;
            x_r <= q_nmag;
            y_r <= q_dmag;
            k_r <= '0;
            state_r <= q_err ? S_OUT : S_GCD;
            q_r <= '0;
          end
        end
        S_GCD: begin
          if (x_r == '0) begin
            g_r <= y_r;
            state_r <= S_SHIFT;
          end else if (!x_r[0] && !y_r[0]) begin
            x_r <= x_r >> 1;
            y_r <= y_r >> 1;
            k_r <= k_r + 1'b1;
          end else if (!x_r[0]) begin
            x_r <= x_r >> 1;
          end else if (!y_r[0]) begin
            y_r <= y_r >> 1;
          end else if (x_r >= y_r) begin
            x_r <= (x_r - y_r) >> 1;
          end else begin
            y_r <= (y_r - x_r) >> 1;
          end
        end
        S_SHIFT: begin
          if (k_r != '0) begin
            g_r <= g_r << 1;
            k_r <= k_r - 1'b1;
          end else begin
            cnt_r <= CW'(MW);
            rem_r <= '0;
            state_r <= S_DIVN;
          end
        end
        S_DIVN, S_DIVD: begin
          if (!trial[MW]) begin
            rem_r <= trial[MW-1:0];
            q_r <= {q_r[MW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[MW-2:0], src[cnt_r - 1'b1]};
            q_r <= {q_r[MW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            if (state_r == S_DIVN) begin
              n_r <= !trial[MW] ? {q_r[MW-2:0], 1'b1} : {q_r[MW-2:0], 1'b0};
              cnt_r <= CW'(MW);
              rem_r <= '0;
              q_r <= '0;
              state_r <= S_DIVD;
            end else begin
              d_r <= !trial[MW] ? {q_r[MW-2:0], 1'b1} : {q_r[MW-2:0], 1'b0};
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_word.zero_den_error <= err_r;
            if (err_r) begin
              out_word.sum_num <= '0;
              out_word.sum_den <= '0;
            end else begin
              out_word.sum_num <= (neg_r && n_r != '0) ?
                  NumBits'(~({{NumBits{1'b0}}, n_r}) + 1'b1) :
                  NumBits'({{NumBits{1'b0}}, n_r});
              out_word.sum_den <= DenBits'({{DenBits{1'b0}}, d_r});
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state_r == S_OUT)) out_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_SHIFT && k_r == '0) |-> g_r != '0)
    else $error("gcd is zero");
  assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == S_IDLE && q_valid) |=> state_r != S_IDLE)
    else $error("queued word dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid && !out_ready) |=> out_valid)
    else $error("result lost");
endmodule

FILE: hw/rtl/fraction_add_reduce_top.sv
// Top level of the fraction add and reduce block.
// Input word a_num/a_den + b_num/b_den on in_*, reduced sum on out_*.
// Depends on far_pkg, far_front and far_back.
// The front end takes one word, registers the operand magnitudes, forms the
// exact products and places the numerator sum and denominator product in a
// one-entry queue register. The back end runs a binary gcd, shifts the gcd
// back up, and then performs two restoring divisions on the shared divider.
// The back end accepts a new queued word as soon as its result is loaded
// into the output register, so the front end may work on the next word.
// A zero denominator skips the gcd and returns zero fields with the flag.
// Reset (synchronous, rst_n low) empties the queue and all stages.
// When the receiver stalls, the result holds on out_word with out_valid high.
// The back end finishes the next word and waits in its output state, the
// queue fills behind it, and in_ready stays low.
module fraction_add_reduce_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  far_pkg::in_word_t in_word,
  output logic out_valid,
  input  logic out_ready,
  output far_pkg::out_word_t out_word
);
  import far_pkg::*;
  localparam int unsigned OPERAND_WIDTH = OperandWidth;
  logic q_valid, q_ready, q_neg, q_err;
  logic [2*OPERAND_WIDTH:0] q_nmag, q_dmag;

  far_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready,
    .a_num(in_word.a_num), .a_den(in_word.a_den),
    .b_num(in_word.b_num), .b_den(in_word.b_den),
    .q_valid, .q_ready, .q_nmag, .q_dmag, .q_neg, .q_err
  );

  far_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_nmag, .q_dmag, .q_neg, .q_err,
    .out_valid, .out_ready, .out_word
  );
endmodule

FILE: tb/testbench.sv
// Testbench for fraction_add_reduce_top: random and directed fraction pairs.
// Predicts each reduced sum in SystemVerilog and checks out_word in order.
// Depends on far_pkg and the fraction_add_reduce_top RTL.
`timescale 1ns / 100ps

module testbench;
  import far_pkg::*;

  localparam int unsigned W = OperandWidth;
  localparam int unsigned WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_word;

  in_word_t pending_words[$];
  out_word_t expected_sums[$];
  int mismatches = 0;
  int checked = 0;
  int errors_seen = 0;
  int idle_cycles = 0;
  bit in_accepted = 1'b0;
  bit hold_recv = 1'b0;
  bit no_idle = 1'b0;
  bit driver_pause = 1'b0;

  fraction_add_reduce_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic out_word_t reduced_sum(in_word_t w);
    out_word_t r;
    longint an, ad, bn, bd, num, den, g, n, d;
    an = longint'(w.a_num);
    ad = longint'(w.a_den);
    bn = longint'(w.b_num);
    bd = longint'(w.b_den);
    r = '0;
    if (ad == 0 || bd == 0) begin
      r.zero_den_error = 1'b1;
      return r;
    end
    num = an * bd + bn * ad;
    den = ad * bd;
    g = longint'(euclid(num < 0 ? -num : num, den < 0 ? -den : den));
    n = num / g;
    d = den / g;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    r.sum_num = n[NumBits-1:0];
    r.sum_den = d[DenBits-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return logic'(W'($urandom_range(0, 3))) ? W'($urandom_range(0, 3)) : '0;
      1: return {1'b1, {(W-1){1'b0}}} + W'($urandom_range(0, 2));
      2: return {1'b0, {(W-1){1'b1}}} - W'($urandom_range(0, 2));
      3: return W'($signed($urandom_range(0, 40)) - 20);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.a_num = rand_operand();
    w.a_den = ($urandom_range(0, 19) == 0) ? '0 : rand_operand();
    w.b_num = rand_operand();
    w.b_den = ($urandom_range(0, 19) == 0) ? '0 : rand_operand();
    return w;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_words.size() > 0 && !driver_pause &&
          (no_idle || $urandom_range(0, 99) >= 23)) begin
        in_word <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_recv) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || $urandom_range(0, 99) >= 23;
    end
  end

  always @(posedge clk) begin
    in_accepted <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_sums.push_back(reduced_sum(in_word));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected word: got %0d/%0d err=%0b", $signed(out_word.sum_num),
                     out_word.sum_den, out_word.zero_den_error);
          end
        end else begin
          out_word_t e;
          e = expected_sums.pop_front();
          checked++;
          if (e.zero_den_error) begin
            errors_seen++;
          end
          if (out_word.sum_num !== e.sum_num || out_word.sum_den !== e.sum_den ||
              out_word.zero_den_error !== e.zero_den_error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected %0d/%0d err=%0b, got %0d/%0d err=%0b",
                       $signed(e.sum_num), e.sum_den, e.zero_den_error,
                       $signed(out_word.sum_num), out_word.sum_den,
                       out_word.zero_den_error);
            end
          end
        end
      end
      if (idle_cycles >= WatchdogLimit && !hold_recv) begin
        $display("watchdog: no progress, %0d words outstanding", expected_sums.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_sums.size() > 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    in_word_t w;
    int signed ext[6];
    ext = '{0, 1, -1, 32767, -32768, 7};
    for (int i = 0; i < 6; i++) begin
      w.a_num = W'(ext[i]);
      w.a_den = W'(ext[(i + 3) % 6]);
      w.b_num = W'(ext[(i + 4) % 6]);
      w.b_den = W'(ext[(i + 1) % 6]);
      pending_words.push_back(w);
    end
    pending_words.push_back('{16'sd1, 16'sd2, -16'sd1, 16'sd2});
    pending_words.push_back('{16'sd3, 16'sd0, 16'sd1, 16'sd5});
    pending_words.push_back('{16'sd3, 16'sd4, 16'sd1, 16'sd0});
    pending_words.push_back('{16'sd2, -16'sd4, 16'sd6, -16'sd8});
    pending_words.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
    pending_words.push_back('{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767});
    pending_words.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32765});
    pending_words.push_back('{16'sd5, 16'sd6, 16'sd7, 16'sd10});
    pending_words.push_back('{16'sd0, -16'sd3, 16'sd0, 16'sd9});
    pending_words.push_back('{-16'sd1, 16'sd1, 16'sd0, 16'sd0});
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait_drained();
    no_idle = 1'b1;
    for (int i = 0; i < 150; i++) pending_words.push_back(rand_word());
    wait_drained();
    no_idle = 1'b0;
    hold_recv = 1'b1;
    for (int i = 0; i < 100; i++) pending_words.push_back(rand_word());
    repeat (3000) @(posedge clk);
    hold_recv = 1'b0;
    wait_drained();
    driver_pause = 1'b1;
    repeat (50) @(posedge clk);
    driver_pause = 1'b0;
    for (int i = 0; i < 780; i++) pending_words.push_back(rand_word());
    wait_drained();
    repeat (400) @(posedge clk);
    $display("Checked %0d sums, %0d of them with a zero denominator.", checked, errors_seen);
    $display("Phases: directed corners, back-to-back, long receiver stall, random idling.");
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/far_pkg.sv
hw/rtl/far_front.sv
hw/rtl/far_back.sv
hw/rtl/fraction_add_reduce_top.sv
tb/testbench.sv
